>>> design/qpad_pkg.sv
// ----------------------------------------------------------------------------
// qpad_pkg
// Shared constants, codes and command/status types of the quad patch
// adjacency detector.
// ----------------------------------------------------------------------------
package qpad_pkg;

    // Geometry
    localparam int COORD_WIDTH = 24;
    localparam int NUM_CORNERS = 4;
    localparam int CORNER_W    = $clog2(NUM_CORNERS);
    localparam int LAST_CORNER = NUM_CORNERS - 1;

    // Distance arithmetic: an axis difference at or above 2**FAR_BIT is far
    localparam int FAR_BIT = 26;
    localparam int SQ_W    = 2 * FAR_BIT;
    localparam int SUM_W   = SQ_W + 2;

    // Configuration
    localparam int TOL_WIDTH  = 52;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 64;
    localparam int REG_TOL    = 0;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

    // Relation codes
    localparam logic [1:0] REL_NONE  = 2'd0;
    localparam logic [1:0] REL_EDGE  = 2'd1;
    localparam logic [1:0] REL_POINT = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic                wr_en;
        logic                start;
        logic [CORNER_W-1:0] addr_a;
        logic [CORNER_W-1:0] addr_b;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic done;
        logic hit;
    } t_dp_stat;

endpackage

>>> design/qpad_in_if.sv
// ----------------------------------------------------------------------------
// qpad_in_if
// Corner channel: one corner of one patch per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qpad_in_if #(
    parameter int COORD_WIDTH = qpad_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic                          patch_select;
    logic [1:0]                    corner_slot;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic                          compare_now;

    modport source (
        output valid, patch_select, corner_slot, coord_x, coord_y, coord_z, compare_now,
        input  ready
    );
    modport sink (
        input  valid, patch_select, corner_slot, coord_x, coord_y, coord_z, compare_now,
        output ready
    );
endinterface

>>> design/qpad_out_if.sv
// ----------------------------------------------------------------------------
// qpad_out_if
// Result channel: one adjacency verdict per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qpad_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] relation;
    logic [1:0] rot_first;
    logic [1:0] rot_second;

    modport source (
        output valid, relation, rot_first, rot_second,
        input  ready
    );
    modport sink (
        input  valid, relation, rot_first, rot_second,
        output ready
    );
endinterface

>>> design/quad_patch_adjacency_detect_unit.sv
// ----------------------------------------------------------------------------
// quad_patch_adjacency_detect_unit
// Detects whether two quadrilateral patches share an edge or a corner.
// ----------------------------------------------------------------------------
// Usage:
//   i_corner carries one corner per beat: patch, slot and x/y/z in signed
//   fixed point with 16 fractional bits. A beat without compare_now only
//   stores the corner and leaves the unit ready. A beat with compare_now
//   stores the corner, then scans the corner pairs (first patch outer) for
//   the first pair with squared distance below the tolerance and checks for
//   a shared edge. o_result carries one beat per compare: relation (none,
//   edge, point) and the two rotation indices.
//   Each pair check passes through the corner RAM read, distance, square
//   and compare stages, and a compare runs 2 to 17 checks one after
//   another; no new corner is taken until the compare's result is loaded
//   into the result register.
//   The tolerance register sits at APB address 0 and resets to 1.
//   Reset empties the result register and returns the controller to idle;
//   corner stores hold garbage until written. A stalled receiver holds the
//   result in place; corners keep loading, and the next compare runs its
//   checks but holds its result until the result register drains.
// ----------------------------------------------------------------------------
module quad_patch_adjacency_detect_unit #(
    parameter int COORD_WIDTH = qpad_pkg::COORD_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    qpad_in_if.sink                            i_corner,
    qpad_out_if.source                         o_result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qpad_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [qpad_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [qpad_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    qpad_pkg::t_dp_cmd                w_cmd;
    qpad_pkg::t_dp_stat               w_stat;
    logic [qpad_pkg::TOL_WIDTH-1:0]   w_tol;

    qpad_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_tol   (w_tol)
    );

    qpad_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_corner (i_corner),
        .o_result (o_result),
        .o_cmd    (w_cmd),
        .i_stat   (w_stat)
    );

    qpad_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_wr_sel  (i_corner.patch_select),
        .i_wr_slot (i_corner.corner_slot),
        .i_wr_x    (i_corner.coord_x),
        .i_wr_y    (i_corner.coord_y),
        .i_wr_z    (i_corner.coord_z),
        .i_tol     (w_tol),
        .o_stat    (w_stat)
    );
endmodule

>>> design/qpad_ram.sv
// ----------------------------------------------------------------------------
// qpad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qpad_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> design/qpad_cfg.sv
// ----------------------------------------------------------------------------
// qpad_cfg
// APB register file holding the coincidence tolerance.
// ----------------------------------------------------------------------------
module qpad_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qpad_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [qpad_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [qpad_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,
    output logic [qpad_pkg::TOL_WIDTH-1:0]       o_tol
);
    localparam logic [qpad_pkg::APB_ADDR_W-1:0] TOL_ADDR =
        qpad_pkg::APB_ADDR_W'(qpad_pkg::REG_TOL * 8);

    logic                             r_tol;
    logic [qpad_pkg::TOL_WIDTH-1:0]   r_tol_val;
    logic [qpad_pkg::TOL_WIDTH-1:0]   n_tol_val;
    logic                             w_hit;

    assign w_hit = (paddr == TOL_ADDR);

    // Take a write in the access phase
    always_comb begin
        n_tol_val = r_tol_val;
        if (psel && penable && pwrite && w_hit) begin
            n_tol_val = pwdata[qpad_pkg::TOL_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol_val <= qpad_pkg::TOL_RESET;
            r_tol     <= 1'b0;
        end else begin
            r_tol_val <= n_tol_val;
            r_tol     <= 1'b1;
        end
    end

    // Read back; nothing else is mapped
    assign prdata = (w_hit && r_tol) ? qpad_pkg::APB_DATA_W'(r_tol_val)
                  : (w_hit ? qpad_pkg::APB_DATA_W'(qpad_pkg::TOL_RESET) : '0);
    assign pready = 1'b1;
    assign o_tol  = r_tol_val;
endmodule

>>> design/qpad_dp.sv
// ----------------------------------------------------------------------------
// qpad_dp
// Datapath: corner stores for both patches and a four-stage squared
// distance check of one corner pair against the tolerance.
// ----------------------------------------------------------------------------
module qpad_dp #(
    parameter int COORD_WIDTH = qpad_pkg::COORD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qpad_pkg::t_dp_cmd                    i_cmd,
    input  logic                                 i_wr_sel,
    input  logic [qpad_pkg::CORNER_W-1:0]        i_wr_slot,
    input  logic signed [COORD_WIDTH-1:0]        i_wr_x,
    input  logic signed [COORD_WIDTH-1:0]        i_wr_y,
    input  logic signed [COORD_WIDTH-1:0]        i_wr_z,
    input  logic [qpad_pkg::TOL_WIDTH-1:0]       i_tol,
    output qpad_pkg::t_dp_stat                   o_stat
);
    localparam int ENTRY_W = 3 * COORD_WIDTH;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int MAG_W   = (DIFF_W > qpad_pkg::FAR_BIT) ? DIFF_W : qpad_pkg::FAR_BIT + 1;
    localparam int FB      = qpad_pkg::FAR_BIT;

    logic [ENTRY_W-1:0] w_wr_data;
    logic [ENTRY_W-1:0] w_rd_a;
    logic [ENTRY_W-1:0] w_rd_b;

    logic signed [COORD_WIDTH-1:0] w_ca [3];
    logic signed [COORD_WIDTH-1:0] w_cb [3];
    logic signed [DIFF_W-1:0]      w_diff [3];
    logic [MAG_W-1:0]              w_mag [3];
    logic [2:0]                    w_far;

    logic                          r_v1, r_v2, r_v3, r_v4;
    logic [FB-1:0]                 r_op [3];
    logic                          r_far2, r_far3;
    logic [qpad_pkg::SQ_W-1:0]     r_sq [3];
    logic                          r_hit;
    logic [qpad_pkg::SUM_W-1:0]    w_sum;

    assign w_wr_data = {i_wr_x, i_wr_y, i_wr_z};

    // First patch corners
    qpad_ram #(.WIDTH(ENTRY_W), .DEPTH(qpad_pkg::NUM_CORNERS)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en && !i_wr_sel),
        .i_wr_addr (i_wr_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.start),
        .i_rd_addr (i_cmd.addr_a),
        .o_rd_data (w_rd_a)
    );

    // Second patch corners
    qpad_ram #(.WIDTH(ENTRY_W), .DEPTH(qpad_pkg::NUM_CORNERS)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en && i_wr_sel),
        .i_wr_addr (i_wr_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.start),
        .i_rd_addr (i_cmd.addr_b),
        .o_rd_data (w_rd_b)
    );

    // Split entries into axes, take differences and magnitudes
    always_comb begin
        w_ca[0] = w_rd_a[3*COORD_WIDTH-1:2*COORD_WIDTH];
        w_ca[1] = w_rd_a[2*COORD_WIDTH-1:COORD_WIDTH];
        w_ca[2] = w_rd_a[COORD_WIDTH-1:0];
        w_cb[0] = w_rd_b[3*COORD_WIDTH-1:2*COORD_WIDTH];
        w_cb[1] = w_rd_b[2*COORD_WIDTH-1:COORD_WIDTH];
        w_cb[2] = w_rd_b[COORD_WIDTH-1:0];
        for (int k = 0; k < 3; k++) begin
            w_diff[k] = DIFF_W'(w_ca[k]) - DIFF_W'(w_cb[k]);
            w_mag[k]  = w_diff[k][DIFF_W-1] ? MAG_W'(DIFF_W'(-w_diff[k]))
                                            : MAG_W'(w_diff[k]);
            w_far[k]  = |w_mag[k][MAG_W-1:FB];
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Magnitudes, squares, then sum and compare
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_op[k] <= w_mag[k][FB-1:0];
            r_sq[k] <= qpad_pkg::SQ_W'(r_op[k]) * qpad_pkg::SQ_W'(r_op[k]);
        end
        r_far2 <= |w_far;
        r_far3 <= r_far2;
        r_hit  <= !r_far3 && (w_sum < qpad_pkg::SUM_W'(i_tol));
    end

    assign w_sum = qpad_pkg::SUM_W'(r_sq[0]) + qpad_pkg::SUM_W'(r_sq[1])
                 + qpad_pkg::SUM_W'(r_sq[2]);

    assign o_stat.done = r_v4;
    assign o_stat.hit  = r_hit;
endmodule

>>> design/qpad_ctrl.sv
// ----------------------------------------------------------------------------
// qpad_ctrl
// Controller: accepts corners, walks the corner pair scan and the edge
// checks one distance check at a time, and holds the result register.
// ----------------------------------------------------------------------------
module qpad_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    qpad_in_if.sink             i_corner,
    qpad_out_if.source          o_result,
    output qpad_pkg::t_dp_cmd   o_cmd,
    input  qpad_pkg::t_dp_stat  i_stat
);
    localparam int CW = qpad_pkg::CORNER_W;
    localparam logic [CW-1:0] LAST = CW'(qpad_pkg::LAST_CORNER);
    localparam logic [CW-1:0] ZERO = '0;

    // States
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Check phases
    localparam logic [1:0] PH_SCAN = 2'd0;
    localparam logic [1:0] PH_NEXT = 2'd1;
    localparam logic [1:0] PH_WRAP = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_i, n_i, r_j, n_j;
    logic [1:0]    r_rel, n_rel;
    logic [CW-1:0] r_r1, n_r1, r_r2, n_r2;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_rel, n_out_rel;
    logic [CW-1:0] r_out_r1, n_out_r1, r_out_r2, n_out_r2;
    logic          w_accept;

    assign i_corner.ready = (r_state == ST_IDLE);
    assign w_accept       = i_corner.valid && (r_state == ST_IDLE);

    // Commands to the datapath
    always_comb begin
        o_cmd.wr_en = w_accept;
        o_cmd.start = (r_state == ST_ISSUE);
        unique case (r_phase)
            PH_SCAN: begin
                o_cmd.addr_a = r_i;
                o_cmd.addr_b = r_j;
            end
            PH_NEXT: begin
                o_cmd.addr_a = CW'(r_i + 1'b1);
                o_cmd.addr_b = CW'(r_j - 1'b1);
            end
            PH_WRAP: begin
                o_cmd.addr_a = LAST;
                o_cmd.addr_b = CW'(r_j + 1'b1);
            end
            default: begin
                o_cmd.addr_a = r_i;
                o_cmd.addr_b = r_j;
            end
        endcase
    end

    // Sequence the checks
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_i         = r_i;
        n_j         = r_j;
        n_rel       = r_rel;
        n_r1        = r_r1;
        n_r2        = r_r2;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_rel   = r_out_rel;
        n_out_r1    = r_out_r1;
        n_out_r2    = r_out_r2;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_corner.compare_now) begin
                    n_state = ST_ISSUE;
                    n_phase = PH_SCAN;
                    n_i     = ZERO;
                    n_j     = ZERO;
                end
            end
            ST_ISSUE: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_stat.done) begin
                    unique case (r_phase)
                        PH_SCAN: begin
                            if (i_stat.hit) begin
                                n_phase = PH_NEXT;
                                n_state = ST_ISSUE;
                            end else if (r_i == LAST && r_j == LAST) begin
                                n_rel   = qpad_pkg::REL_NONE;
                                n_r1    = ZERO;
                                n_r2    = ZERO;
                                n_state = ST_DONE;
                            end else begin
                                n_j     = CW'(r_j + 1'b1);
                                n_i     = (r_j == LAST) ? CW'(r_i + 1'b1) : r_i;
                                n_state = ST_ISSUE;
                            end
                        end
                        PH_NEXT: begin
                            if (i_stat.hit) begin
                                n_rel   = qpad_pkg::REL_EDGE;
                                n_r1    = r_i;
                                n_r2    = CW'(r_j - 1'b1);
                                n_state = ST_DONE;
                            end else if (r_i == ZERO) begin
                                n_phase = PH_WRAP;
                                n_state = ST_ISSUE;
                            end else begin
                                n_rel   = qpad_pkg::REL_POINT;
                                n_r1    = r_i;
                                n_r2    = r_j;
                                n_state = ST_DONE;
                            end
                        end
                        PH_WRAP: begin
                            n_rel   = i_stat.hit ? qpad_pkg::REL_EDGE : qpad_pkg::REL_POINT;
                            n_r1    = i_stat.hit ? LAST : r_i;
                            n_r2    = r_j;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_rel   = qpad_pkg::REL_NONE;
                            n_r1    = ZERO;
                            n_r2    = ZERO;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                // Load the result once the output register is free
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid = 1'b1;
                    n_out_rel   = r_rel;
                    n_out_r1    = r_r1;
                    n_out_r2    = r_r2;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SCAN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    // Scan position and result payload
    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_j       <= n_j;
        r_rel     <= n_rel;
        r_r1      <= n_r1;
        r_r2      <= n_r2;
        r_out_rel <= n_out_rel;
        r_out_r1  <= n_out_r1;
        r_out_r2  <= n_out_r2;
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.relation   = r_out_rel;
    assign o_result.rot_first  = r_out_r1;
    assign o_result.rot_second = r_out_r2;
endmodule

>>> design/qpad_chk.sv
// ----------------------------------------------------------------------------
// qpad_chk
// Port-level checks of the adjacency detector, bound to the top level.
// ----------------------------------------------------------------------------
module qpad_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_compare,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_out_relation,
    input logic [1:0] i_out_rot_first,
    input logic [1:0] i_out_rot_second
);
    // Hold a result beat until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // No contact reports zero rotations
    a_none_rot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_relation == qpad_pkg::REL_NONE
        |-> i_out_rot_first == 2'd0 && i_out_rot_second == 2'd0)
        else $error("rotation set without contact");

    // Relation stays within its codes
    a_rel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_relation == qpad_pkg::REL_NONE
                     || i_out_relation == qpad_pkg::REL_EDGE
                     || i_out_relation == qpad_pkg::REL_POINT)
        else $error("illegal relation code");

    // A compare beat blocks the corner channel while it runs
    a_cmp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_compare |=> !i_in_ready)
        else $error("corner taken during a compare");

    // A compare never answers in the next cycle
    a_cmp_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_compare && !i_out_valid |=> !i_out_valid)
        else $error("result too early");
endmodule

bind quad_patch_adjacency_detect_unit qpad_chk u_qpad_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_corner.valid),
    .i_in_ready       (i_corner.ready),
    .i_in_compare     (i_corner.compare_now),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_out_relation   (o_result.relation),
    .i_out_rot_first  (o_result.rot_first),
    .i_out_rot_second (o_result.rot_second)
);

>>> test/quad_patch_adjacency_detect_unit_tb.sv
// ----------------------------------------------------------------------------
// quad_patch_adjacency_detect_unit_tb
// Self-checking bench for the quad patch adjacency detector. Corner beats go
// in through the corner channel and are mirrored into a local corner store.
// Each compare beat predicts the verdict (first coinciding pair, shared edge
// test with the corner-zero wrap, shared point), and every verdict beat is
// checked in order. The tolerance register is swept over several settings.
// Both channels idle at random, and the result side stalls for long stretches.
// ----------------------------------------------------------------------------

typedef struct {
    logic signed [qpad_pkg::COORD_WIDTH-1:0] x;
    logic signed [qpad_pkg::COORD_WIDTH-1:0] y;
    logic signed [qpad_pkg::COORD_WIDTH-1:0] z;
} t_point;

typedef struct {
    logic       patch_select;
    logic [1:0] corner_slot;
    t_point     pt;
    logic       compare_now;
} t_corner;

typedef struct {
    logic [1:0] relation;
    logic [1:0] rot_first;
    logic [1:0] rot_second;
} t_verdict;

// Corner store mirror, verdict predictor and in-order verdict checker
class contact_scoreboard;
    logic signed [qpad_pkg::COORD_WIDTH-1:0] px[8];
    logic signed [qpad_pkg::COORD_WIDTH-1:0] py[8];
    logic signed [qpad_pkg::COORD_WIDTH-1:0] pz[8];
    logic [qpad_pkg::TOL_WIDTH-1:0]          tolerance;
    t_verdict                                verdicts_due[$];
    int unsigned mismatch_count;
    int unsigned verdict_count;
    int unsigned edge_count;
    int unsigned point_count;
    int unsigned apart_count;

    function new();
        tolerance = qpad_pkg::TOL_RESET;
        foreach (px[k]) begin
            px[k] = '0;
            py[k] = '0;
            pz[k] = '0;
        end
    endfunction

    function void flag_mismatch(string msg);
        if (mismatch_count < 10) begin
            $display("mismatch: %s", msg);
        end
        mismatch_count++;
    endfunction

    // Squared distance of first corner a and second corner b below tolerance
    function bit corners_meet(int a, int b);
        int     p;
        int     q;
        longint dx;
        longint dy;
        longint dz;
        longint far_lim;
        p = a & qpad_pkg::LAST_CORNER;
        q = qpad_pkg::NUM_CORNERS + (b & qpad_pkg::LAST_CORNER);
        far_lim = longint'(1) << qpad_pkg::FAR_BIT;
        dx = longint'(px[p]) - longint'(px[q]);
        dy = longint'(py[p]) - longint'(py[q]);
        dz = longint'(pz[p]) - longint'(pz[q]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dz < 0) dz = -dz;
        if (dx >= far_lim || dy >= far_lim || dz >= far_lim) begin
            return 1'b0;
        end
        return (dx * dx + dy * dy + dz * dz) < longint'(tolerance);
    endfunction

    // Scan first patch outer, second inner; classify around the first hit
    function t_verdict judge_adjacency();
        t_verdict v;
        bit       found;
        v.relation   = qpad_pkg::REL_NONE;
        v.rot_first  = 2'd0;
        v.rot_second = 2'd0;
        found = 1'b0;
        for (int i = 0; i < qpad_pkg::NUM_CORNERS && !found; i++) begin
            for (int j = 0; j < qpad_pkg::NUM_CORNERS && !found; j++) begin
                if (corners_meet(i, j)) begin
                    found = 1'b1;
                    if (corners_meet(i + 1, j + 3)) begin
                        v.relation   = qpad_pkg::REL_EDGE;
                        v.rot_first  = 2'(i);
                        v.rot_second = 2'(j + 3);
                    end else if (i == 0 && corners_meet(3, j + 1)) begin
                        v.relation   = qpad_pkg::REL_EDGE;
                        v.rot_first  = 2'(qpad_pkg::LAST_CORNER);
                        v.rot_second = 2'(j);
                    end else begin
                        v.relation   = qpad_pkg::REL_POINT;
                        v.rot_first  = 2'(i);
                        v.rot_second = 2'(j);
                    end
                end
            end
        end
        return v;
    endfunction

    function void note_corner(t_corner c);
        int       k;
        t_verdict v;
        k = int'({c.patch_select, c.corner_slot});
        px[k] = c.pt.x;
        py[k] = c.pt.y;
        pz[k] = c.pt.z;
        if (c.compare_now) begin
            v = judge_adjacency();
            verdicts_due.push_back(v);
            case (v.relation)
                qpad_pkg::REL_EDGE:  edge_count++;
                qpad_pkg::REL_POINT: point_count++;
                default:             apart_count++;
            endcase
        end
    endfunction

    function void check_verdict(t_verdict got);
        t_verdict want;
        verdict_count++;
        if (verdicts_due.size() == 0) begin
            flag_mismatch($sformatf("verdict with none pending: rel %0d rot %0d/%0d",
                                    got.relation, got.rot_first, got.rot_second));
            return;
        end
        want = verdicts_due.pop_front();
        if (got.relation !== want.relation || got.rot_first !== want.rot_first ||
            got.rot_second !== want.rot_second) begin
            flag_mismatch($sformatf("verdict %0d: exp rel %0d rot %0d/%0d, got rel %0d rot %0d/%0d",
                                    verdict_count, want.relation, want.rot_first,
                                    want.rot_second, got.relation, got.rot_first,
                                    got.rot_second));
        end
    endfunction
endclass

module quad_patch_adjacency_detect_unit_tb;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_WAIT   = 100;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ITEMS  = 95;
    localparam int NUM_PHASES   = 6;
    localparam int CW           = qpad_pkg::COORD_WIDTH;
    localparam int TW           = qpad_pkg::TOL_WIDTH;
    localparam int AW           = qpad_pkg::APB_ADDR_W;
    localparam int DW           = qpad_pkg::APB_DATA_W;
    localparam int CMAX         = (1 << (CW - 1)) - 1;
    localparam int CMIN         = -(1 << (CW - 1));
    localparam logic [TW-1:0] TOL_MAX  = '1;
    localparam logic [AW-1:0] TOL_ADDR = AW'(8 * qpad_pkg::REG_TOL);

    logic          i_clk;
    logic          i_rst_n;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [DW-1:0] pwdata;
    logic [DW-1:0] prdata;
    logic          pready;

    qpad_in_if #(.COORD_WIDTH(CW)) corner_bus();
    qpad_out_if                    verdict_bus();

    quad_patch_adjacency_detect_unit #(
        .COORD_WIDTH(CW)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_corner (corner_bus),
        .o_result (verdict_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    contact_scoreboard sb = new();

    int unsigned items_sent;
    int unsigned tol_settings;
    bit          sender_calm;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Hard stop for a hung run
    initial begin
        #4000000;
        $display("timeout: %0d verdicts still pending", sb.verdicts_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 16) return $urandom_range(1, 3);
        if (r < 19) return $urandom_range(4, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [CW-1:0] clamp_coord(longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return CW'(v);
    endfunction

    function automatic t_point make_point(longint x, longint y, longint z);
        t_point p;
        p.x = clamp_coord(x);
        p.y = clamp_coord(y);
        p.z = clamp_coord(z);
        return p;
    endfunction

    // Spread 0 covers the full range, higher spreads cluster near the origin
    function automatic t_point random_point(int spread);
        t_point p;
        int     lim;
        if (spread == 0) begin
            p.x = CW'($urandom());
            p.y = CW'($urandom());
            p.z = CW'($urandom());
        end else begin
            lim = (spread == 1) ? (1 << 18) : (1 << 10);
            p = make_point(int'($urandom_range(0, 2 * lim)) - lim,
                           int'($urandom_range(0, 2 * lim)) - lim,
                           int'($urandom_range(0, 2 * lim)) - lim);
        end
        return p;
    endfunction

    // Nudge a point by zero, a few LSBs, a fraction or about one unit
    function automatic t_point jitter_point(t_point p);
        int lim;
        case ($urandom_range(0, 3))
            0:       lim = 0;
            1:       lim = 3;
            2:       lim = 1023;
            default: lim = 65536;
        endcase
        return make_point(longint'(p.x) + int'($urandom_range(0, 2 * lim)) - lim,
                          longint'(p.y) + int'($urandom_range(0, 2 * lim)) - lim,
                          longint'(p.z) + int'($urandom_range(0, 2 * lim)) - lim);
    endfunction

    function automatic t_point stored_point(int k);
        t_point p;
        p.x = sb.px[k];
        p.y = sb.py[k];
        p.z = sb.pz[k];
        return p;
    endfunction

    // Offer one corner beat and hold it until accepted
    task automatic send_corner(bit patch, int slot, t_point p, bit cmp);
        t_corner c;
        int      gap;
        gap = sender_calm ? 0 : pick_idle();
        if (gap > 0) begin
            corner_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        c.patch_select = patch;
        c.corner_slot  = 2'(slot);
        c.pt           = p;
        c.compare_now  = cmp;
        corner_bus.valid        <= 1'b1;
        corner_bus.patch_select <= c.patch_select;
        corner_bus.corner_slot  <= c.corner_slot;
        corner_bus.coord_x      <= p.x;
        corner_bus.coord_y      <= p.y;
        corner_bus.coord_z      <= p.z;
        corner_bus.compare_now  <= cmp;
        do @(posedge i_clk); while (!corner_bus.ready);
        sb.note_corner(c);
        items_sent++;
    endtask

    // Drop valid and hold until every predicted verdict has come back
    task automatic wait_for_verdicts();
        corner_bus.valid <= 1'b0;
        do @(posedge i_clk); while (sb.verdicts_due.size() != 0);
    endtask

    task automatic apb_write(logic [TW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOL_ADDR;
        pwdata  <= DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.tolerance = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(logic [TW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TOL_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DW'(value)) begin
            sb.flag_mismatch($sformatf("tolerance readback: exp %h, got %h",
                                       DW'(value), prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Retune only with the block drained and settled
    task automatic set_tolerance(logic [TW-1:0] value);
        wait_for_verdicts();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        apb_write(value);
        apb_read_check(value);
        tol_settings++;
    endtask

    // Two fresh patches, usually with planted shared corners, loaded in random order
    task automatic send_patch_pair();
        t_point pts[8];
        int     order[8];
        int     spread;
        int     t;
        int     s;
        int     tmp;
        int     k;
        spread = $urandom_range(0, 2);
        for (k = 0; k < 8; k++) begin
            pts[k] = random_point(spread);
            order[k] = k;
        end
        t = $urandom_range(0, 3);
        s = $urandom_range(0, 3);
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                pts[4 + s]             = jitter_point(pts[t]);
                pts[4 + ((s + 3) & 3)] = jitter_point(pts[(t + 1) & 3]);
            end
            2: pts[4 + s] = jitter_point(pts[t]);
            3: begin
                pts[4 + s]             = jitter_point(pts[t]);
                pts[4 + ((s + 1) & 3)] = jitter_point(pts[(t + 3) & 3]);
            end
            default: begin
                for (k = 4; k < 8; k++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        pts[k] = jitter_point(pts[$urandom_range(0, 3)]);
                    end
                end
            end
        endcase
        for (k = 7; k > 0; k--) begin
            t = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[t];
            order[t] = tmp;
        end
        for (k = 0; k < 8; k++) begin
            send_corner(1'(order[k] >> 2), order[k] & 3, pts[order[k]],
                        (k == 7) || ($urandom_range(0, 11) == 0));
        end
    endtask

    // Touch a few corners, often copying another stored corner, then compare
    task automatic send_partial_update();
        t_point p;
        int     n;
        int     slot;
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            slot = $urandom_range(0, 7);
            if ($urandom_range(0, 2) != 0) begin
                p = jitter_point(stored_point($urandom_range(0, 7)));
            end else begin
                p = random_point($urandom_range(0, 2));
            end
            send_corner(1'(slot >> 2), slot & 3, p, k == n - 1);
        end
    endtask

    // Full-range corners with random compare flags
    task automatic send_noise();
        int n;
        int slot;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            slot = $urandom_range(0, 7);
            send_corner(1'(slot >> 2), slot & 3, random_point(0),
                        1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: check each verdict beat, stall at random, hold off twice
    initial begin : verdict_sink
        t_verdict    got;
        int          stall_left;
        int          holds_done;
        int unsigned cyc;
        bit          calm;
        stall_left = 0;
        holds_done = 0;
        cyc = 0;
        calm = 1'b0;
        verdict_bus.ready = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (verdict_bus.valid && verdict_bus.ready) begin
                got.relation   = verdict_bus.relation;
                got.rot_first  = verdict_bus.rot_first;
                got.rot_second = verdict_bus.rot_second;
                sb.check_verdict(got);
            end
            if (cyc % 256 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if (holds_done < 2 && sb.verdict_count >= 15 + 45 * holds_done) begin
                verdict_bus.ready <= 1'b0;
                holds_done++;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (stall_left > 0) begin
                verdict_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                verdict_bus.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    stall_left = pick_idle();
                end
            end
        end
    end

    // Corner side: reset, directed cases, then tolerance phases of random beats
    initial begin : corner_source
        t_point         pa;
        t_point         pb;
        t_point         pc;
        t_point         pd;
        t_point         pe;
        t_point         pf;
        t_point         pg;
        t_point         ph;
        logic [TW-1:0]  tol_list[NUM_PHASES];
        int unsigned    target;
        int             r;

        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        corner_bus.valid        = 1'b0;
        corner_bus.patch_select = 1'b0;
        corner_bus.corner_slot  = '0;
        corner_bus.coord_x      = '0;
        corner_bus.coord_y      = '0;
        corner_bus.coord_z      = '0;
        corner_bus.compare_now  = 1'b0;
        items_sent   = 0;
        tol_settings = 0;
        sender_calm  = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        apb_read_check(qpad_pkg::TOL_RESET);

        // Directed part at the reset tolerance: exact matches only
        pa = make_point(CMAX, CMIN, CMAX);
        pb = make_point(CMIN, CMAX, CMIN);
        pc = make_point(0, 0, 0);
        pd = make_point(1, -1, 65536);
        pe = make_point(CMIN, CMIN, CMIN);
        pf = make_point(CMAX, CMAX, CMAX);
        pg = make_point(-65536, 12345, -1);
        ph = make_point(1193046, -144470, 7);
        // Disjoint patches, widest coordinates: no contact
        send_corner(0, 0, pa, 0);
        send_corner(0, 1, pb, 0);
        send_corner(0, 2, pc, 0);
        send_corner(0, 3, pd, 0);
        send_corner(1, 0, pe, 0);
        send_corner(1, 1, pf, 0);
        send_corner(1, 2, pg, 0);
        send_corner(1, 3, ph, 1);
        // Shared edge on the forward neighbor
        send_corner(1, 1, pb, 0);
        send_corner(1, 2, pa, 1);
        // Shared edge through the corner-zero wrap
        send_corner(1, 1, pe, 0);
        send_corner(1, 3, pd, 1);
        // Single shared point at corner zero
        send_corner(1, 3, ph, 1);
        // Single shared point further into the scan
        send_corner(1, 2, pc, 1);
        // Shared edge with the second patch index wrapping below zero
        send_corner(1, 2, pg, 0);
        send_corner(1, 3, pd, 0);
        send_corner(1, 0, pc, 1);
        // Compare launched from a first patch beat
        send_corner(0, 0, pe, 1);

        // Random phases across tolerance extremes and mid values
        tol_list[0] = qpad_pkg::TOL_RESET;
        tol_list[1] = '0;
        tol_list[2] = TOL_MAX;
        tol_list[3] = TW'(64'd1 << 32);
        tol_list[4] = TW'(64'd1 << 20);
        tol_list[5] = TW'({$urandom(), $urandom()});
        tol_list[5] = tol_list[5] >> $urandom_range(0, 40);
        for (int ph_idx = 0; ph_idx < NUM_PHASES; ph_idx++) begin
            set_tolerance(tol_list[ph_idx]);
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                sender_calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 19);
                if (r < 13) begin
                    send_patch_pair();
                end else if (r < 17) begin
                    send_partial_update();
                end else if (r < 19) begin
                    send_noise();
                end else begin
                    wait_for_verdicts();
                end
            end
        end

        // Drain, let the pipeline settle, then judge the run
        wait_for_verdicts();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.verdicts_due.size() != 0) begin
            sb.flag_mismatch($sformatf("%0d verdicts never arrived", sb.verdicts_due.size()));
        end
        $display("Covered %0d corner beats and %0d verdicts over %0d tolerance settings.",
                 items_sent, sb.verdict_count, tol_settings);
        $display("Verdict mix: %0d shared edge, %0d shared point, %0d apart; %0d mismatches.",
                 sb.edge_count, sb.point_count, sb.apart_count, sb.mismatch_count);
        if (sb.mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/qpad_pkg.sv
design/qpad_in_if.sv
design/qpad_out_if.sv
design/qpad_ram.sv
design/qpad_cfg.sv
design/qpad_dp.sv
design/qpad_ctrl.sv
design/quad_patch_adjacency_detect_unit.sv
design/qpad_chk.sv
test/quad_patch_adjacency_detect_unit_tb.sv
